// ===== rtl/adsr_sine_note_synth_assert.svh =====
// Assertion macros used by the checker file of the note synthesizer.
`ifndef ADSR_SINE_NOTE_SYNTH_ASSERT_SVH
`define ADSR_SINE_NOTE_SYNTH_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ANSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ANSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/anss_pkg.sv =====
// Types, constants and the sine table function of the ADSR sine note synthesizer.
package anss_pkg;

    localparam int PHASE_BITS_DEF      = 24;
    localparam int TABLE_ADDR_BITS_DEF = 8;
    localparam int SAMPLE_RATE         = 44100;

    localparam int LEN_W      = 17;
    localparam int LVL_W      = 13;
    localparam int RAMP_W     = 20;
    localparam int FRAC_W     = 16;
    localparam int ENV_W      = 29;
    localparam int STEP_W     = 24;
    localparam int CNT_W      = 32;
    localparam int SINE_W     = 16;
    localparam int SAMPLE_W   = 14;
    localparam int MAG_W      = ENV_W + SINE_W - 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int DIGIT_W    = 4;
    localparam int PH_DIGITS  = STEP_W / DIGIT_W;
    localparam int MAG_DIGITS = SINE_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(PH_DIGITS);

    localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};

    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int LEN_RESET   = (SAMPLE_RATE > LEN_MAX) ? LEN_MAX : SAMPLE_RATE;
    localparam int ATTACK_RST  = LEN_RESET * 3 / 10;
    localparam int DECAY_RST   = LEN_RESET * 4 / 10;
    localparam int SUSTAIN_RST = LEN_RESET * 9 / 10;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned SERIES_DEN [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOTE_LENGTH   = 3'd0,
        CFG_ATTACK_END    = 3'd1,
        CFG_DECAY_END     = 3'd2,
        CFG_SUSTAIN_END   = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4,
        CFG_ATTACK_RISE   = 3'd5,
        CFG_DECAY_FALL    = 3'd6,
        CFG_RELEASE_FALL  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]  note_length;
        logic [LEN_W-1:0]  attack_end;
        logic [LEN_W-1:0]  decay_end;
        logic [LEN_W-1:0]  sustain_end;
        logic [LVL_W-1:0]  sustain_level;
        logic [RAMP_W-1:0] attack_rise;
        logic [RAMP_W-1:0] decay_fall;
        logic [RAMP_W-1:0] release_fall;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        note_length:   LEN_W'(LEN_RESET),
        attack_end:    LEN_W'(ATTACK_RST),
        decay_end:     LEN_W'(DECAY_RST),
        sustain_end:   LEN_W'(SUSTAIN_RST),
        sustain_level: LVL_W'(5000),
        attack_rise:   RAMP_W'(29721),
        decay_fall:    RAMP_W'(14861),
        release_fall:  RAMP_W'(74303)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_LOOK,
        ST_MAG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_mul_ctrl;

    typedef struct packed {
        logic clear;
        logic advance;
    } t_env_ctrl;

    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          acc;
        int              k;
        x    = ((2 * longint'(idx) + 1) * PI_Q30) >> (addr_bits + 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 0; k < 6; k++) begin
            term = ((term * x2) >> 30) / SERIES_DEN[k];
            if ((k % 2) == 0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
        end
        scaled = ((longint'(acc) * 65535) + (64'd1 << 29)) >> 30;
        return scaled[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/anss_in_if.sv =====
// Request channel: note kind and phase step.
interface anss_in_if;
    import anss_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [STEP_W-1:0] phase_step;

    modport source (output valid, kind, phase_step, input ready);
    modport sink   (input valid, kind, phase_step, output ready);
endinterface

// ===== rtl/anss_out_if.sv =====
// Result channel: signed audio sample and last-position flag.
interface anss_out_if;
    import anss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       note_last;

    modport source (output valid, sample, note_last, input ready);
    modport sink   (input valid, sample, note_last, output ready);
endinterface

// ===== rtl/adsr_sine_note_synth.sv =====
// Top level of the ADSR sine note synthesizer.
// Each request yields one signed sample, and the next request is accepted only once the
// previous result has moved into the output register. The steps in order: the accept, the
// 4-bit digit-serial phase multiply, the sine table lookup, the 4-bit digit-serial
// envelope multiply and the move of the result into the output register. For a continued
// note the envelope ramp is applied in the first multiply cycle. A finished result
// waits in the output register while the next request is already accepted; a result still
// waiting when the next one finishes holds the block in its final cycle.
module adsr_sine_note_synth #(
    parameter int PHASE_BITS      = anss_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = anss_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [anss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [anss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    anss_in_if.sink                          i_req,
    anss_out_if.source                       o_rsp
);
    import anss_pkg::*;

    t_cfg                  r_cfg;
    t_state                r_state, n_state;
    logic [DIG_CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_count;
    logic [STEP_W-1:0]     r_step;
    logic                  r_neg;
    logic                  r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_last;

    logic                  w_in_acc;
    logic                  w_out_load;
    logic [STEP_W-1:0]     w_step;
    t_mul_ctrl             w_ph_ctrl;
    t_mul_ctrl             w_mag_ctrl;
    t_env_ctrl             w_env_ctrl;
    logic [PHASE_BITS-1:0] w_phase;
    logic [SINE_W-1:0]     w_entry;
    logic                  w_neg;
    logic [ENV_W-1:0]      w_env;
    logic                  w_last;
    logic [MAG_W-1:0]      w_mag;
    logic [SAMPLE_W-1:0]   w_mag_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NOTE_LENGTH:   r_cfg.note_length   <= i_cfg_data[LEN_W-1:0];
                CFG_ATTACK_END:    r_cfg.attack_end    <= i_cfg_data[LEN_W-1:0];
                CFG_DECAY_END:     r_cfg.decay_end     <= i_cfg_data[LEN_W-1:0];
                CFG_SUSTAIN_END:   r_cfg.sustain_end   <= i_cfg_data[LEN_W-1:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_data[LVL_W-1:0];
                CFG_ATTACK_RISE:   r_cfg.attack_rise   <= i_cfg_data[RAMP_W-1:0];
                CFG_DECAY_FALL:    r_cfg.decay_fall    <= i_cfg_data[RAMP_W-1:0];
                CFG_RELEASE_FALL:  r_cfg.release_fall  <= i_cfg_data[RAMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_acc = i_req.valid && i_req.ready;
    assign w_step   = i_req.kind ? r_step : i_req.phase_step;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (r_cnt == DIG_CNT_W'(PH_DIGITS - 1)) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_MAG;
            end
            ST_MAG: begin
                if (r_cnt == DIG_CNT_W'(MAG_DIGITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        w_ph_ctrl   = '0;
        w_mag_ctrl  = '0;
        w_env_ctrl  = '0;
        w_out_load  = 1'b0;
        n_cnt       = r_cnt;
        case (r_state)
            ST_IDLE: begin
                i_req.ready        = 1'b1;
                w_ph_ctrl.load     = i_req.valid;
                w_env_ctrl.clear   = i_req.valid && !i_req.kind;
                w_env_ctrl.advance = i_req.valid && i_req.kind;
                n_cnt              = '0;
            end
            ST_PHASE: begin
                w_ph_ctrl.shift = 1'b1;
                n_cnt = (r_cnt == DIG_CNT_W'(PH_DIGITS - 1)) ? '0 : r_cnt + 1'b1;
            end
            ST_LOOK: begin
                w_mag_ctrl.load = 1'b1;
            end
            ST_MAG: begin
                w_mag_ctrl.shift = 1'b1;
                n_cnt = (r_cnt == DIG_CNT_W'(MAG_DIGITS - 1)) ? '0 : r_cnt + 1'b1;
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_in_acc) begin
                r_count <= r_count + 1'b1;
                r_step  <= w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_neg <= w_neg;
        end
    end

    anss_envelope u_envelope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctrl  (w_env_ctrl),
        .o_env   (w_env),
        .o_last  (w_last)
    );

    anss_phase_mul #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_mul (
        .i_clk     (i_clk),
        .i_ctrl    (w_ph_ctrl),
        .i_mcand   (r_count[PHASE_BITS-1:0]),
        .i_mplier  (w_step),
        .o_product (w_phase)
    );

    anss_sine_lookup #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_sine_lookup (
        .i_phase (w_phase),
        .o_entry (w_entry),
        .o_neg   (w_neg)
    );

    anss_env_mul u_env_mul (
        .i_clk   (i_clk),
        .i_ctrl  (w_mag_ctrl),
        .i_env   (w_env),
        .i_entry (w_entry),
        .o_mag   (w_mag)
    );

    assign w_mag_ext = SAMPLE_W'(w_mag);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_sample <= r_neg ? (~w_mag_ext + 1'b1) : w_mag_ext;
            r_last   <= w_last;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sample    = r_sample;
    assign o_rsp.note_last = r_last;
endmodule

// ===== rtl/anss_envelope.sv =====
// Note position counter and linear ADSR envelope ramp.
module anss_envelope (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  anss_pkg::t_cfg              i_cfg,
    input  anss_pkg::t_env_ctrl         i_ctrl,
    output logic [anss_pkg::ENV_W-1:0]  o_env,
    output logic                        o_last
);
    import anss_pkg::*;

    logic [LEN_W-1:0] r_pos, n_pos;
    logic [ENV_W-1:0] r_env, n_env;
    logic             r_apply;
    logic [LEN_W-1:0] w_last;
    logic [ENV_W:0]   w_sum;
    logic [ENV_W-1:0] w_decay;
    logic [ENV_W-1:0] w_release;

    assign w_last    = (i_cfg.note_length == '0) ? '0 : i_cfg.note_length - 1'b1;
    assign w_sum     = {1'b0, r_env} + (ENV_W + 1)'(i_cfg.attack_rise);
    assign w_decay   = ENV_W'(i_cfg.decay_fall);
    assign w_release = ENV_W'(i_cfg.release_fall);

    always_comb begin
        n_pos = r_pos;
        n_env = r_env;
        if (i_ctrl.clear) begin
            n_pos = '0;
            n_env = '0;
        end else if (i_ctrl.advance) begin
            if (r_pos < w_last) begin
                n_pos = r_pos + 1'b1;
            end
        end else if (r_apply) begin
            if (r_pos <= i_cfg.attack_end) begin
                n_env = w_sum[ENV_W] ? ENV_MAX : w_sum[ENV_W-1:0];
            end else if (r_pos <= i_cfg.decay_end) begin
                n_env = (r_env > w_decay) ? r_env - w_decay : '0;
            end else if (r_pos <= i_cfg.sustain_end) begin
                n_env = {i_cfg.sustain_level, {FRAC_W{1'b0}}};
            end else begin
                n_env = (r_env > w_release) ? r_env - w_release : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_env   <= '0;
            r_apply <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_env   <= n_env;
            r_apply <= i_ctrl.advance;
        end
    end

    assign o_env  = r_env;
    assign o_last = (r_pos >= w_last);
endmodule

// ===== rtl/anss_phase_mul.sv =====
// Digit-serial multiplier keeping the low phase bits of step times sample count.
module anss_phase_mul #(
    parameter int PHASE_BITS = anss_pkg::PHASE_BITS_DEF
) (
    input  logic                         i_clk,
    input  anss_pkg::t_mul_ctrl          i_ctrl,
    input  logic [PHASE_BITS-1:0]        i_mcand,
    input  logic [anss_pkg::STEP_W-1:0]  i_mplier,
    output logic [PHASE_BITS-1:0]        o_product
);
    import anss_pkg::*;

    logic [PHASE_BITS-1:0]         r_acc, n_acc;
    logic [PHASE_BITS-1:0]         r_mcand, n_mcand;
    logic [STEP_W-1:0]             r_mplier, n_mplier;
    logic [PHASE_BITS+DIGIT_W-1:0] w_part;

    assign w_part = (PHASE_BITS + DIGIT_W)'(r_mcand)
                  * (PHASE_BITS + DIGIT_W)'(r_mplier[DIGIT_W-1:0]);

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_ctrl.load) begin
            n_acc    = '0;
            n_mcand  = i_mcand;
            n_mplier = i_mplier;
        end else if (i_ctrl.shift) begin
            n_acc    = r_acc + w_part[PHASE_BITS-1:0];
            n_mcand  = r_mcand << DIGIT_W;
            n_mplier = r_mplier >> DIGIT_W;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_product = r_acc;
endmodule

// ===== rtl/anss_sine_lookup.sv =====
// Quarter-wave sine table with quadrant folding of the phase.
module anss_sine_lookup #(
    parameter int PHASE_BITS      = anss_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = anss_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic [PHASE_BITS-1:0]        i_phase,
    output logic [anss_pkg::SINE_W-1:0]  o_entry,
    output logic                         o_neg
);
    import anss_pkg::*;

    localparam int TBL_N = 1 << TABLE_ADDR_BITS;

    logic [SINE_W-1:0]                     w_table [TBL_N];
    logic [PHASE_BITS+TABLE_ADDR_BITS-1:0] w_ext;
    logic [TABLE_ADDR_BITS-1:0]            w_idx;
    logic [TABLE_ADDR_BITS-1:0]            w_addr;
    logic [1:0]                            w_quad;

    for (genvar g = 0; g < TBL_N; g++) begin : g_table
        assign w_table[g] = sine_entry(int'(g), TABLE_ADDR_BITS);
    end

    assign w_ext   = {i_phase, {TABLE_ADDR_BITS{1'b0}}};
    assign w_idx   = w_ext[PHASE_BITS-2 +: TABLE_ADDR_BITS];
    assign w_quad  = i_phase[PHASE_BITS-1 -: 2];
    assign w_addr  = w_quad[0] ? ~w_idx : w_idx;
    assign o_entry = w_table[w_addr];
    assign o_neg   = w_quad[1];
endmodule

// ===== rtl/anss_env_mul.sv =====
// Digit-serial multiplier giving the high bits of envelope times sine entry.
module anss_env_mul (
    input  logic                         i_clk,
    input  anss_pkg::t_mul_ctrl          i_ctrl,
    input  logic [anss_pkg::ENV_W-1:0]   i_env,
    input  logic [anss_pkg::SINE_W-1:0]  i_entry,
    output logic [anss_pkg::MAG_W-1:0]   o_mag
);
    import anss_pkg::*;

    logic [ENV_W-1:0]         r_acc, n_acc;
    logic [ENV_W-1:0]         r_env, n_env;
    logic [SINE_W-1:0]        r_entry, n_entry;
    logic [ENV_W+DIGIT_W-1:0] w_sum;

    assign w_sum = (ENV_W + DIGIT_W)'(r_acc)
                 + (ENV_W + DIGIT_W)'(r_env) * (ENV_W + DIGIT_W)'(r_entry[DIGIT_W-1:0]);

    always_comb begin
        n_acc   = r_acc;
        n_env   = r_env;
        n_entry = r_entry;
        if (i_ctrl.load) begin
            n_acc   = '0;
            n_env   = i_env;
            n_entry = i_entry;
        end else if (i_ctrl.shift) begin
            n_acc   = w_sum[ENV_W+DIGIT_W-1:DIGIT_W];
            n_entry = r_entry >> DIGIT_W;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_env   <= n_env;
        r_entry <= n_entry;
    end

    assign o_mag = r_acc[ENV_W-1 -: MAG_W];
endmodule

// ===== rtl/anss_checker.sv =====
// Port-level assertions for the note synthesizer and their binding to the top level.
`include "adsr_sine_note_synth_assert.svh"

module anss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [anss_pkg::SAMPLE_W-1:0]   i_out_sample
);
    import anss_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    `ANSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped before accepted")
    `ANSS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !i_in_ready, "request accepted while one is in flight")
    `ANSS_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, w_in_acc && !i_out_valid, !i_out_valid, "result appeared right after request")
    `ANSS_ASSERT_NOW(a_sample_range, i_clk, i_rst_n, i_out_valid, i_out_sample != {1'b1, {(SAMPLE_W - 1){1'b0}}}, "sample outside symmetric range")
endmodule

bind adsr_sine_note_synth anss_checker u_anss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_sample (o_rsp.sample)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the ADSR sine note synthesizer: directed table, then random notes.
module testbench;
    import anss_pkg::*;

    typedef longint unsigned u64_t;

    localparam int     HALF_PERIOD = 5;
    localparam int     TBL_BITS    = TABLE_ADDR_BITS_DEF;
    localparam int     TBL_SIZE    = 1 << TBL_BITS;
    localparam int     PH_W        = PHASE_BITS_DEF;
    localparam int     SETTLE_CYC  = 20;
    localparam int     HOLD_CYC    = 300;
    localparam int     DRAIN_LIMIT = 20000;
    localparam int     MAX_REPORTS = 10;
    localparam int     PHASE_ITEMS = 35;
    localparam longint TIMEOUT_NS  = 64'd10_000_000;
    localparam u64_t   PI_FIX      = 64'd3373259426;

    localparam logic [LEN_W-1:0]  BOUND_TOP = '1;
    localparam logic [RAMP_W-1:0] RAMP_TOP  = '1;
    localparam logic [LVL_W-1:0]  LEVEL_TOP = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } note_out_t;

    typedef struct {
        bit                    is_cfg;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  kind;
        logic [STEP_W-1:0]     step;
        bit                    typed;
        note_out_t             typed_out;
    } plan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    anss_in_if  req_if ();
    anss_out_if rsp_if ();

    adsr_sine_note_synth DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    logic [SINE_W-1:0] quarter_sine [TBL_SIZE];
    t_cfg              shadow_cfg;
    logic [CNT_W-1:0]  sample_cnt;
    logic [STEP_W-1:0] note_step;
    logic [LEN_W-1:0]  note_pos;
    logic [ENV_W-1:0]  env_level;
    note_out_t         pending_samples [$];
    plan_row_t         plan [$];

    int errors;
    int n_items;
    int n_results;
    int n_notes;
    int n_cfg;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_req;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic logic [SINE_W-1:0] quarter_sine_at(input int unsigned idx);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint acc;
        int     k;
        x    = (u64_t'(2 * idx + 1) * PI_FIX) / u64_t'(4 * TBL_SIZE);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / u64_t'(2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
        end
        return SINE_W'((u64_t'(acc) * 65535 + (64'd1 << 29)) >> 30);
    endfunction

    task automatic advance_synth(input logic kind, input logic [STEP_W-1:0] step,
                                 output note_out_t res);
        logic [LEN_W-1:0]        last_pos;
        logic [CNT_W:0]          rise_sum;
        logic [STEP_W+CNT_W-1:0] phase_prod;
        logic [PH_W-1:0]         phase;
        logic [TBL_BITS-1:0]     tbl_idx;
        logic [ENV_W+SINE_W-1:0] env_prod;
        logic [MAG_W-1:0]        mag;
        last_pos = (shadow_cfg.note_length == 0) ? '0 : shadow_cfg.note_length - 1'b1;
        if (kind == 1'b0) begin
            note_step = step;
            note_pos  = '0;
            env_level = '0;
        end else begin
            if (note_pos < last_pos) begin
                note_pos = note_pos + 1'b1;
            end
            if (note_pos <= shadow_cfg.attack_end) begin
                rise_sum  = env_level + shadow_cfg.attack_rise;
                env_level = (rise_sum > ENV_MAX) ? ENV_MAX : rise_sum[ENV_W-1:0];
            end else if (note_pos <= shadow_cfg.decay_end) begin
                env_level = (env_level > shadow_cfg.decay_fall)
                          ? env_level - shadow_cfg.decay_fall : '0;
            end else if (note_pos <= shadow_cfg.sustain_end) begin
                env_level = {shadow_cfg.sustain_level, {FRAC_W{1'b0}}};
            end else begin
                env_level = (env_level > shadow_cfg.release_fall)
                          ? env_level - shadow_cfg.release_fall : '0;
            end
        end
        phase_prod = note_step * sample_cnt;
        phase      = phase_prod[PH_W-1:0];
        tbl_idx    = phase[PH_W-3 -: TBL_BITS];
        if (phase[PH_W-2]) begin
            tbl_idx = ~tbl_idx;
        end
        env_prod   = env_level * quarter_sine[tbl_idx];
        mag        = env_prod[ENV_W+SINE_W-1 -: MAG_W];
        res.sample = phase[PH_W-1] ? SAMPLE_W'(0) - SAMPLE_W'(mag) : SAMPLE_W'(mag);
        res.last   = (note_pos >= last_pos);
        sample_cnt = sample_cnt + 1'b1;
    endtask

    task automatic send_item(input logic kind, input logic [STEP_W-1:0] step,
                             input bit typed, input note_out_t typed_out);
        note_out_t predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.kind       = kind;
        req_if.phase_step = step;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        advance_synth(kind, step, predicted);
        pending_samples.push_back(typed ? typed_out : predicted);
        n_items++;
        if (kind == 1'b0) begin
            n_notes++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_NOTE_LENGTH:   shadow_cfg.note_length   = val[LEN_W-1:0];
            CFG_ATTACK_END:    shadow_cfg.attack_end    = val[LEN_W-1:0];
            CFG_DECAY_END:     shadow_cfg.decay_end     = val[LEN_W-1:0];
            CFG_SUSTAIN_END:   shadow_cfg.sustain_end   = val[LEN_W-1:0];
            CFG_SUSTAIN_LEVEL: shadow_cfg.sustain_level = val[LVL_W-1:0];
            CFG_ATTACK_RISE:   shadow_cfg.attack_rise   = val[RAMP_W-1:0];
            CFG_DECAY_FALL:    shadow_cfg.decay_fall    = val[RAMP_W-1:0];
            CFG_RELEASE_FALL:  shadow_cfg.release_fall  = val[RAMP_W-1:0];
            default: begin
            end
        endcase
        n_cfg++;
    endtask

    function automatic void add_item(input logic kind, input logic [STEP_W-1:0] step,
                                     input bit typed, input logic signed [SAMPLE_W-1:0] es,
                                     input logic el);
        plan_row_t row;
        row.is_cfg           = 1'b0;
        row.reg_idx          = CFG_NOTE_LENGTH;
        row.value            = '0;
        row.kind             = kind;
        row.step             = step;
        row.typed            = typed;
        row.typed_out.sample = es;
        row.typed_out.last   = el;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.is_cfg    = 1'b1;
        row.reg_idx   = idx;
        row.value     = val;
        row.kind      = 1'b0;
        row.step      = '0;
        row.typed     = 1'b0;
        row.typed_out = '0;
        plan.push_back(row);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return STEP_W'(1) << $urandom_range(0, STEP_W - 1);
            default: return STEP_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extreme(input logic [CFG_DATA_W-1:0] top);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return top;
            default: return CFG_DATA_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bound(input int span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'(BOUND_TOP);
            default: return CFG_DATA_W'($urandom_range(0, span));
        endcase
    endfunction

    task automatic run_random_phase(input int target, input bit hold_rx, input bit pause_mid);
        int               sent;
        int               span;
        int               count;
        int               k;
        bit               paused;
        logic [LEN_W-1:0] len;
        settle_block();
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LEN_W'(1);
            2:       len = BOUND_TOP;
            default: len = LEN_W'($urandom_range(2, 40));
        endcase
        span = (len > 40) ? 42 : int'(len) + 2;
        write_reg(CFG_NOTE_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_ATTACK_END, pick_bound(span));
        write_reg(CFG_DECAY_END, pick_bound(span));
        write_reg(CFG_SUSTAIN_END, pick_bound(span));
        write_reg(CFG_SUSTAIN_LEVEL, pick_extreme(CFG_DATA_W'(LEVEL_TOP)));
        write_reg(CFG_ATTACK_RISE, pick_extreme(RAMP_TOP));
        write_reg(CFG_DECAY_FALL, pick_extreme(RAMP_TOP));
        write_reg(CFG_RELEASE_FALL, pick_extreme(RAMP_TOP));
        if (hold_rx) begin
            stall_req++;
        end
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            if (pause_mid && !paused && sent >= target / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                send_item(1'b0, pick_step(), 1'b0, '0);
                sent++;
                count = (len > 48) ? int'($urandom_range(3, 20))
                      : ((len > 0) ? int'(len) - 1 : 0) + int'($urandom_range(0, 3));
                for (k = 0; k < count; k++) begin
                    send_item(1'b1, STEP_W'($urandom), 1'b0, '0);
                    sent++;
                end
            end else begin
                count = $urandom_range(1, 3);
                for (k = 0; k < count; k++) begin
                    send_item($urandom_range(0, 1) == 1, pick_step(), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // hold off the result channel for a long stretch on each stall request
    initial begin
        int hold_left;
        int stall_seen;
        rsp_if.ready = 1'b0;
        hold_left    = 0;
        stall_seen   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_seen != stall_req) begin
                stall_seen = stall_req;
                hold_left  = HOLD_CYC;
            end
            if (hold_left != 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        note_out_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (pending_samples.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result: sample %0d note_last %0b",
                             rsp_if.sample, rsp_if.note_last);
                end
            end else begin
                want = pending_samples.pop_front();
                if (rsp_if.sample !== want.sample || rsp_if.note_last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("result %0d: sample exp %0d got %0d, note_last exp %0b got %0b",
                                 n_results, want.sample, rsp_if.sample, want.last,
                                 rsp_if.note_last);
                    end
                end
            end
        end
    end

    initial begin
        int guard;
        bit quiet;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.kind       = 1'b0;
        req_if.phase_step = '0;
        errors            = 0;
        n_items           = 0;
        n_results         = 0;
        n_notes           = 0;
        n_cfg             = 0;
        stall_req         = 0;
        send_idle_pct     = 24;
        recv_idle_pct     = 73;
        for (int i = 0; i < TBL_SIZE; i++) begin
            quarter_sine[i] = quarter_sine_at(i);
        end
        shadow_cfg = '{note_length:   LEN_W'(44100),
                       attack_end:    LEN_W'(13230),
                       decay_end:     LEN_W'(17640),
                       sustain_end:   LEN_W'(39690),
                       sustain_level: LVL_W'(5000),
                       attack_rise:   RAMP_W'(29721),
                       decay_fall:    RAMP_W'(14861),
                       release_fall:  RAMP_W'(74303)};
        sample_cnt = '0;
        note_step  = '0;
        note_pos   = '0;
        env_level  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_item(1'b1, 24'h123456, 1'b1, '0, 1'b0);
        add_item(1'b0, '1, 1'b1, '0, 1'b0);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_item(1'b1, '1, 1'b0, '0, 1'b0);
        add_item(1'b0, 24'h800000, 1'b1, '0, 1'b0);
        add_item(1'b1, 24'h800000, 1'b0, '0, 1'b0);
        add_cfg(CFG_NOTE_LENGTH, '0);
        add_item(1'b0, 24'h400000, 1'b1, '0, 1'b1);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_cfg(CFG_NOTE_LENGTH, CFG_DATA_W'(4));
        add_cfg(CFG_ATTACK_END, '0);
        add_cfg(CFG_DECAY_END, '0);
        add_cfg(CFG_SUSTAIN_END, CFG_DATA_W'(BOUND_TOP));
        add_cfg(CFG_SUSTAIN_LEVEL, CFG_DATA_W'(LEVEL_TOP));
        add_item(1'b0, 24'h0C0000, 1'b1, '0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            add_item(1'b1, '0, 1'b0, '0, 1'b0);
        end
        add_cfg(CFG_ATTACK_END, CFG_DATA_W'(BOUND_TOP));
        add_cfg(CFG_ATTACK_RISE, RAMP_TOP);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_cfg(CFG_NOTE_LENGTH, CFG_DATA_W'(2));
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_cfg(CFG_ATTACK_END, '0);
        add_cfg(CFG_SUSTAIN_END, '0);
        add_cfg(CFG_RELEASE_FALL, RAMP_TOP);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);
        add_item(1'b0, '1, 1'b1, '0, 1'b0);
        add_item(1'b1, '0, 1'b1, '0, 1'b1);
        add_item(1'b1, '0, 1'b0, '0, 1'b0);

        quiet = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!quiet) begin
                    settle_block();
                    quiet = 1'b1;
                end
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_item(plan[i].kind, plan[i].step, plan[i].typed, plan[i].typed_out);
                quiet = 1'b0;
            end
        end

        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
        send_idle_pct = 73;
        recv_idle_pct = 24;
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
        run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);

        @(negedge i_clk);
        req_if.valid = 1'b0;
        guard = 0;
        while (pending_samples.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_samples.size() != 0) begin
            errors += pending_samples.size();
            $display("%0d expected samples never arrived", pending_samples.size());
        end
        $display("%0d requests in %0d notes, %0d samples checked, %0d register writes, %0d errors",
                 n_items, n_notes, n_results, n_cfg, errors);
        $display("edge-case table, random envelopes under three idle mixes and one output stall");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/anss_pkg.sv
rtl/anss_in_if.sv
rtl/anss_out_if.sv
rtl/anss_envelope.sv
rtl/anss_phase_mul.sv
rtl/anss_sine_lookup.sv
rtl/anss_env_mul.sv
rtl/adsr_sine_note_synth.sv
rtl/anss_checker.sv
bench/testbench.sv
